### rtl/chst_pkg.sv
// ----------------------------------------------------------------------------
// chst_pkg
// Shared types and constants of the chained hash symbol table.
// ----------------------------------------------------------------------------
package chst_pkg;

    localparam int LINK_W         = 10;
    localparam int HASH_W         = 8;
    localparam int HEAD_CNT       = 256;
    localparam int NAME_HI_W      = 64;
    localparam int NAME_LO_W      = 32;
    localparam int NAME_W         = NAME_HI_W + NAME_LO_W;
    localparam int VALUE_W        = 16;
    localparam int BYTES_PER_STEP = 4;
    localparam int HASH_STEPS     = NAME_W / (8 * BYTES_PER_STEP);
    localparam int HCNT_W         = $clog2(HASH_STEPS);

    localparam logic OP_LOOKUP   = 1'b0;
    localparam logic OP_DEFINE   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic head_rd;
        logic ent_rd;
        logic follow;
        logic finish_hit;
        logic finish_miss;
    } t_cmd;

    typedef struct packed {
        logic hash_last;
        logic link_null;
        logic match;
    } t_sts;

endpackage

### rtl/chained_hash_symbol_table.sv
// ----------------------------------------------------------------------------
// chained_hash_symbol_table
// Symbol table of 12-byte names with 16-bit values, 256 hash chains.
// ----------------------------------------------------------------------------
// An item is taken when i_start is high and o_busy is low. Its result shows
// for one cycle with o_valid; the receiver cannot hold it off. After the
// accepting edge the block hashes the name, four name bytes a cycle, then
// reads the chain head, then visits chain entries, each with one
// registered entry memory read and one compare, until a hit or the end of
// the chain. The result strobe cycle already accepts the next item. Chain
// heads carry valid bits, so no clearing pass follows reset.
module chained_hash_symbol_table
    import chst_pkg::*;
#(
    parameter int MAX_ENTRIES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_operation,
    input  logic [NAME_HI_W-1:0] i_name_high,
    input  logic [NAME_LO_W-1:0] i_name_low,
    input  logic [VALUE_W-1:0]   i_value,
    output logic                 o_valid,
    output logic                 o_found,
    output logic [VALUE_W-1:0]   o_stored_value,
    output logic                 o_status
);

    t_cmd w_cmd;
    t_sts w_sts;

    chst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    chst_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_operation    (i_operation),
        .i_name_high    (i_name_high),
        .i_name_low     (i_name_low),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_stored_value (o_stored_value),
        .o_status       (o_status)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_FULL)) |-> (!o_found && (o_stored_value == '0)))
        else $error("table full result carries a hit");
`endif

endmodule

### rtl/chst_ctrl.sv
// ----------------------------------------------------------------------------
// chst_ctrl
// Sequencer: hash, head read, then chain walk until hit or end of chain.
// ----------------------------------------------------------------------------
module chst_ctrl
    import chst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_CHK,
        S_CMP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = S_HASH;
                    n_busy  = 1'b1;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_last) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_sts.link_null) begin
                    o_cmd.finish_miss = 1'b1;
                    n_state           = S_IDLE;
                    n_busy            = 1'b0;
                end else begin
                    o_cmd.ent_rd = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state          = S_IDLE;
                    n_busy           = 1'b0;
                end else begin
                    o_cmd.follow = 1'b1;
                    n_state      = S_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

### rtl/chst_dp.sv
// ----------------------------------------------------------------------------
// chst_dp
// Datapath: item registers, hash unit, chain head and entry memories,
// result registers.
// ----------------------------------------------------------------------------
module chst_dp
    import chst_pkg::*;
#(
    parameter int MAX_ENTRIES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_operation,
    input  logic [NAME_HI_W-1:0] i_name_high,
    input  logic [NAME_LO_W-1:0] i_name_low,
    input  logic [VALUE_W-1:0]   i_value,
    output logic                 o_valid,
    output logic                 o_found,
    output logic [VALUE_W-1:0]   o_stored_value,
    output logic                 o_status
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    // item registers
    logic                 r_op;
    logic [NAME_HI_W-1:0] r_hi;
    logic [NAME_LO_W-1:0] r_lo;
    logic [VALUE_W-1:0]   r_val;

    // hash unit
    logic [HASH_W-1:0]    r_hash, n_hash;
    logic                 r_hstop, n_hstop;
    logic [HCNT_W-1:0]    r_hcnt;

    // walk
    logic [LINK_W-1:0]    r_link;
    logic [LINK_W-1:0]    r_head_link;
    logic [LINK_W-1:0]    r_used;

    // memories
    logic [LINK_W-1:0]    r_head_mem [HEAD_CNT];
    logic [HEAD_CNT-1:0]  r_head_vld;
    logic [NAME_HI_W-1:0] r_ent_hi   [MAX_ENTRIES];
    logic [NAME_LO_W-1:0] r_ent_lo   [MAX_ENTRIES];
    logic [VALUE_W-1:0]   r_ent_val  [MAX_ENTRIES];
    logic [LINK_W-1:0]    r_ent_next [MAX_ENTRIES];
    logic [NAME_HI_W-1:0] r_q_hi;
    logic [NAME_LO_W-1:0] r_q_lo;
    logic [VALUE_W-1:0]   r_q_val;
    logic [LINK_W-1:0]    r_q_next;

    // results
    logic                 r_valid;
    logic                 r_found;
    logic [VALUE_W-1:0]   r_stored;
    logic                 r_status;

    logic [NAME_W-1:0]    w_name;
    logic [8*BYTES_PER_STEP-1:0] w_group;
    logic [IDX_W-1:0]     w_link_idx;
    logic [IDX_W-1:0]     w_new_idx;
    logic                 w_full;
    logic                 w_new_we;
    logic                 w_val_we;
    logic [IDX_W-1:0]     w_val_addr;

    assign w_name     = {r_hi, r_lo};
    assign w_group    = w_name[NAME_W-1 - 8*BYTES_PER_STEP*r_hcnt -: 8*BYTES_PER_STEP];
    assign w_link_idx = IDX_W'(r_link - LINK_W'(1));
    assign w_new_idx  = IDX_W'(r_used);
    assign w_full     = (r_used >= LINK_W'(MAX_ENTRIES));
    assign w_new_we   = i_cmd.finish_miss && (r_op == OP_DEFINE) && !w_full;
    assign w_val_we   = w_new_we || (i_cmd.finish_hit && (r_op == OP_DEFINE));
    assign w_val_addr = i_cmd.finish_hit ? w_link_idx : w_new_idx;

    // four bytes per step, stop at the first zero byte
    always_comb begin
        logic [7:0] c;
        n_hash  = r_hash;
        n_hstop = r_hstop;
        for (int k = 0; k < BYTES_PER_STEP; k++) begin
            c = w_group[8*(BYTES_PER_STEP-1-k) +: 8];
            if (!n_hstop) begin
                if (c == 8'd0) begin
                    n_hstop = 1'b1;
                end else begin
                    n_hash = {n_hash[HASH_W-2:0], 1'b0} + c;
                end
            end
        end
    end

    assign o_sts.hash_last = (r_hcnt == HCNT_W'(HASH_STEPS - 1));
    assign o_sts.link_null = (r_link == '0) || (r_link > r_used);
    assign o_sts.match     = (r_q_hi == r_hi) && (r_q_lo == r_lo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_hi  <= i_name_high;
            r_lo  <= i_name_low;
            r_val <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hash  <= '0;
            r_hstop <= 1'b0;
            r_hcnt  <= '0;
        end else if (i_cmd.hash_step) begin
            r_hash  <= n_hash;
            r_hstop <= n_hstop;
            r_hcnt  <= r_hcnt + HCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_rd) begin
            r_link      <= r_head_vld[r_hash] ? r_head_mem[r_hash] : '0;
            r_head_link <= r_head_vld[r_hash] ? r_head_mem[r_hash] : '0;
        end else if (i_cmd.follow) begin
            r_link <= r_q_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
            r_used     <= '0;
        end else if (w_new_we) begin
            r_head_vld[r_hash] <= 1'b1;
            r_used             <= r_used + LINK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_new_we) begin
            r_head_mem[r_hash] <= r_used + LINK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_new_we) begin
            r_ent_hi[w_new_idx]   <= r_hi;
            r_ent_lo[w_new_idx]   <= r_lo;
            r_ent_next[w_new_idx] <= r_head_link;
        end
        if (w_val_we) begin
            r_ent_val[w_val_addr] <= r_val;
        end
        if (i_cmd.ent_rd) begin
            r_q_hi   <= r_ent_hi[w_link_idx];
            r_q_lo   <= r_ent_lo[w_link_idx];
            r_q_val  <= r_ent_val[w_link_idx];
            r_q_next <= r_ent_next[w_link_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish_hit || i_cmd.finish_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_hit) begin
            r_found  <= 1'b1;
            r_stored <= r_q_val;
            r_status <= STATUS_OK;
        end else if (i_cmd.finish_miss) begin
            r_found  <= 1'b0;
            r_stored <= '0;
            r_status <= ((r_op == OP_DEFINE) && w_full) ? STATUS_FULL : STATUS_OK;
        end
    end

    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_stored_value = r_stored;
    assign o_status       = r_status;

endmodule

### tb/tb_chained_hash_symbol_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chained_hash_symbol_table
// Self-checking bench for the chained hash symbol table. A queue of lookup
// and define items (directed corner names, then random traffic that fills
// the table past capacity) feeds a start/busy driver with random idle gaps.
// Every accepted item is run through a bench-side copy of the table, and
// each result strobe is compared against the oldest predicted answer.
// ----------------------------------------------------------------------------
module tb_chained_hash_symbol_table;
    import chst_pkg::*;

    localparam int TABLE_DEPTH  = 512;
    localparam int ITEM_COUNT   = 800;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 4 * (ITEM_COUNT + TABLE_DEPTH) * (2 * TABLE_DEPTH + 16);
    localparam logic [7:0] CROWD_BYTE = 8'h5A;

    typedef enum int {SHAPE_TEXT, SHAPE_RAW, SHAPE_CROWDED, SHAPE_BLANK_HEAD} t_name_shape;

    typedef struct {
        logic                 op;
        logic [NAME_HI_W-1:0] name_high;
        logic [NAME_LO_W-1:0] name_low;
        logic [VALUE_W-1:0]   value;
    } t_symbol_req;

    typedef struct {
        logic               found;
        logic [VALUE_W-1:0] stored_value;
        logic               status;
    } t_symbol_ans;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_start        = 1'b0;
    logic                 i_operation    = OP_LOOKUP;
    logic [NAME_HI_W-1:0] i_name_high    = '0;
    logic [NAME_LO_W-1:0] i_name_low     = '0;
    logic [VALUE_W-1:0]   i_value        = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic                 o_found;
    logic [VALUE_W-1:0]   o_stored_value;
    logic                 o_status;

    t_symbol_req symbol_requests[$];
    t_symbol_ans symbol_answers[$];
    t_symbol_req next_req;
    t_symbol_ans want;
    logic [NAME_W-1:0] name_pool[$];

    // bench copy of the table
    logic [LINK_W-1:0]  chain_head [HEAD_CNT];
    logic [NAME_W-1:0]  slot_name  [TABLE_DEPTH];
    logic [VALUE_W-1:0] slot_value [TABLE_DEPTH];
    logic [LINK_W-1:0]  slot_next  [TABLE_DEPTH];
    int                 slots_used = 0;

    logic item_taken = 1'b0;
    bit   no_idle    = 1'b0;
    int   idle_left  = 0;
    int   fail_count = 0;
    int   cycle_count = 0;

    chained_hash_symbol_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_operation    (i_operation),
        .i_name_high    (i_name_high),
        .i_name_low     (i_name_low),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_stored_value (o_stored_value),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_symbol_ans table_access(t_symbol_req req);
        logic [NAME_W-1:0] name;
        logic [7:0]        ch;
        logic [HASH_W-1:0] bucket;
        logic [LINK_W-1:0] link;
        logic [LINK_W-1:0] hit;
        bit                stop;
        int                steps;
        t_symbol_ans       ans;
        name   = {req.name_high, req.name_low};
        bucket = '0;
        stop   = 1'b0;
        for (int k = 0; k < 12; k++) begin
            ch = name[NAME_W-1-8*k -: 8];
            if (ch == 8'h00) stop = 1'b1;
            if (!stop) bucket = {bucket[HASH_W-2:0], 1'b0} + ch;
        end
        link  = chain_head[bucket];
        hit   = '0;
        steps = 0;
        while (link != 0 && steps < TABLE_DEPTH) begin
            if (link > slots_used) break;
            if (slot_name[link-1] == name) begin
                hit = link;
                break;
            end
            link = slot_next[link-1];
            steps++;
        end
        ans = '{1'b0, '0, STATUS_OK};
        if (hit != 0) begin
            ans.found        = 1'b1;
            ans.stored_value = slot_value[hit-1];
            if (req.op == OP_DEFINE) slot_value[hit-1] = req.value;
        end else if (req.op == OP_DEFINE) begin
            if (slots_used >= TABLE_DEPTH) begin
                ans.status = STATUS_FULL;
            end else begin
                slot_name[slots_used]  = name;
                slot_value[slots_used] = req.value;
                slot_next[slots_used]  = chain_head[bucket];
                chain_head[bucket]     = LINK_W'(slots_used + 1);
                slots_used++;
            end
        end
        return ans;
    endfunction

    function automatic logic [NAME_W-1:0] make_name(t_name_shape shape);
        logic [NAME_W-1:0] name;
        int                len;
        name = {$urandom, $urandom, $urandom};
        case (shape)
            SHAPE_TEXT: begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < 12; k++)
                    name[NAME_W-1-8*k -: 8] = (k < len) ? 8'($urandom_range(1, 255)) : 8'h00;
            end
            SHAPE_CROWDED: begin
                name[NAME_W-1 -: 16] = {CROWD_BYTE, 8'h00};
            end
            SHAPE_BLANK_HEAD: begin
                name[NAME_W-1 -: 8] = 8'h00;
            end
            default: begin
            end
        endcase
        return name;
    endfunction

    function automatic t_name_shape pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return SHAPE_TEXT;
        if (r < 65) return SHAPE_RAW;
        if (r < 85) return SHAPE_CROWDED;
        return SHAPE_BLANK_HEAD;
    endfunction

    function automatic void queue_item(logic op, logic [NAME_W-1:0] name,
                                       logic [VALUE_W-1:0] value);
        t_symbol_req req;
        req = '{op, name[NAME_W-1 -: NAME_HI_W], name[NAME_LO_W-1:0], value};
        symbol_requests.push_back(req);
        if (op == OP_DEFINE) name_pool.push_back(name);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || item_taken) begin
            if (idle_left > 0) begin
                i_start   <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (symbol_requests.size() > 0) begin
                next_req = symbol_requests.pop_front();
                i_operation <= next_req.op;
                i_name_high <= next_req.name_high;
                i_name_low  <= next_req.name_low;
                i_value     <= next_req.value;
                i_start     <= 1'b1;
                if ($urandom_range(0, 31) == 0) no_idle <= !no_idle;
                idle_left <= no_idle ? 0 : $urandom_range(0, 6);
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            if (o_valid) begin
                if (symbol_answers.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    fail_count++;
                end else begin
                    want = symbol_answers.pop_front();
                    if (o_found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, o_found);
                        fail_count++;
                    end
                    if (o_stored_value !== want.stored_value) begin
                        $error("stored_value: expected %0h, got %0h",
                               want.stored_value, o_stored_value);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                end
            end
            item_taken <= i_start && !o_busy;
            if (i_start && !o_busy)
                symbol_answers.push_back(table_access('{i_operation, i_name_high,
                                                        i_name_low, i_value}));
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [NAME_W-1:0] name;
        int                r;
        int                new_defines;
        new_defines = 0;
        foreach (chain_head[b]) chain_head[b] = '0;

        // directed: empty and full-ones names, tails after a zero byte, hash collisions
        queue_item(OP_LOOKUP, '0, 16'hFFFF);
        queue_item(OP_DEFINE, '0, 16'hFFFF);
        queue_item(OP_LOOKUP, '0, 16'h0000);
        queue_item(OP_DEFINE, '1, 16'h0000);
        queue_item(OP_LOOKUP, '1, 16'hFFFF);
        queue_item(OP_DEFINE, '1, 16'h1234);
        queue_item(OP_LOOKUP, '1, 16'h0000);
        queue_item(OP_DEFINE, 96'h41_00000000000000_00000000, 16'h0001);
        queue_item(OP_DEFINE, 96'h41_00000000000000_00000001, 16'h0002);
        queue_item(OP_LOOKUP, 96'h41_00000000000000_00000000, 16'h0000);
        queue_item(OP_LOOKUP, 96'h41_00000000000000_00000001, 16'h0000);
        queue_item(OP_LOOKUP, 96'h41_000000000000FF_00000000, 16'h0000);
        queue_item(OP_DEFINE, 96'h4C4F4E475F4E414D455F3132, 16'h8000);
        queue_item(OP_LOOKUP, 96'h4C4F4E475F4E414D455F3132, 16'h0000);
        queue_item(OP_DEFINE, 96'h4142_000000000000_00000000, 16'h00FF);
        queue_item(OP_DEFINE, 96'hC4_00000000000000_00000000, 16'hFF00);
        queue_item(OP_LOOKUP, 96'h4142_000000000000_00000000, 16'h0000);
        queue_item(OP_LOOKUP, 96'hC4_00000000000000_00000000, 16'h0000);
        queue_item(OP_DEFINE, 96'hC4_00000000000000_00000000, 16'h7FFF);
        queue_item(OP_LOOKUP, 96'hC4_00000000000000_00000000, 16'h0000);

        // random: mostly new defines so the table fills and overflows
        for (int n = 0; n < ITEM_COUNT; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_item(OP_DEFINE, make_name(pick_shape()), 16'($urandom_range(0, 65535)));
                new_defines++;
            end else if (r < 82) begin
                name = name_pool[$urandom_range(0, name_pool.size() - 1)];
                queue_item(OP_DEFINE, name, 16'($urandom_range(0, 65535)));
            end else if (r < 94) begin
                name = name_pool[$urandom_range(0, name_pool.size() - 1)];
                queue_item(OP_LOOKUP, name, 16'($urandom_range(0, 65535)));
            end else begin
                queue_item(OP_LOOKUP, make_name(pick_shape()), 16'($urandom_range(0, 65535)));
            end
        end
        while (new_defines < TABLE_DEPTH + 24) begin
            queue_item(OP_DEFINE, make_name(pick_shape()), 16'($urandom_range(0, 65535)));
            new_defines++;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (symbol_requests.size() != 0 || i_start) @(posedge i_clk);
        while (symbol_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
rtl/chst_pkg.sv
rtl/chst_ctrl.sv
rtl/chst_dp.sv
rtl/chained_hash_symbol_table.sv
tb/tb_chained_hash_symbol_table.sv
